/* rtl/mbp_pkg.sv */
// Shared types and constants for the MSB-first bit packer.
// Used by every module of the block; no dependencies.
package mbp_pkg;

	localparam int unsigned WORD_BITS       = 32;
	localparam int unsigned BYTE_BITS       = 8;
	localparam int unsigned ACC_BITS        = WORD_BITS + BYTE_BITS;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	// Item modes
	typedef enum logic {
		MODE_WRITE = 1'b0,
		MODE_FLUSH = 1'b1
	} mode_t;

	// One packed job: completed bytes left-aligned, plus how many of them are valid.
	typedef struct packed {
		logic [WORD_BITS-1:0] data;
		logic [2:0]           nbytes;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

/* rtl/mbp_front.sv */
// Front part of the bit packer: accepts items, merges them with the pending bits
// and hands completed bytes to the job queue. Depends on mbp_pkg.
module mbp_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       mode,
	input  logic [31:0]                value,
	input  logic [5:0]                 bit_count,
	input  mbp_pkg::q_status_t         q_status,
	output logic                       push,
	output mbp_pkg::job_t              push_job
);

	logic [2:0]                      pend_cnt_q;
	logic [6:0]                      pend_bits_q;
	logic                            flush;
	logic                            accept;
	logic [5:0]                      n_sat;
	logic [5:0]                      n_eff;
	logic [31:0]                     val_al;
	logic [mbp_pkg::ACC_BITS-1:0]    pend_left;
	logic [mbp_pkg::ACC_BITS-1:0]    word;
	logic [mbp_pkg::ACC_BITS-1:0]    rest;
	logic [5:0]                      len;
	logic [2:0]                      nbytes;
	logic [2:0]                      new_cnt;
	logic [6:0]                      new_bits;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;
	assign flush    = (mode == mbp_pkg::MODE_FLUSH);

	always_comb begin
		n_sat = (bit_count > 6'd32) ? 6'd32 : bit_count;
		n_eff = flush ? (6'd8 - {3'b000, pend_cnt_q}) : n_sat;
		// left-align the new bits; bits above the count fall off the top
		if (flush || n_sat == 6'd0) begin
			val_al = '0;
		end else begin
			val_al = value << (6'd32 - n_sat);
		end
		pend_left = {pend_bits_q, 33'b0} << (3'd7 - pend_cnt_q);
		word      = pend_left | ({val_al, 8'b0} >> pend_cnt_q);
		len       = {3'b000, pend_cnt_q} + n_eff;
		nbytes    = (flush && pend_cnt_q == 3'd0) ? 3'd0 : len[5:3];
		new_cnt   = len[2:0];
		rest      = word << {nbytes, 3'b000};
		new_bits  = rest[mbp_pkg::ACC_BITS-1 -: 7] >> (3'd7 - new_cnt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q  <= '0;
			pend_bits_q <= '0;
		end else if (accept && !(flush && pend_cnt_q == 3'd0)) begin
			pend_cnt_q  <= new_cnt;
			pend_bits_q <= new_bits;
		end
	end

	assign push            = accept && (nbytes != 3'd0);
	assign push_job.data   = word[mbp_pkg::ACC_BITS-1 -: mbp_pkg::WORD_BITS];
	assign push_job.nbytes = nbytes;

endmodule

/* rtl/mbp_queue.sv */
// Short job queue between the front and back parts of the bit packer.
// Depends on mbp_pkg.
module mbp_queue #(
	parameter int unsigned DEPTH = mbp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mbp_pkg::job_t      push_job,
	input  logic               pop,
	output mbp_pkg::job_t      head_job,
	output mbp_pkg::q_status_t status
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	mbp_pkg::job_t  mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign head_job     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/mbp_back.sv */
// Back part of the bit packer: takes jobs off the queue and sends their bytes
// one beat at a time from an output register. Depends on mbp_pkg.
module mbp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mbp_pkg::job_t       head_job,
	input  mbp_pkg::q_status_t  q_status,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                last
);

	logic [mbp_pkg::WORD_BITS-1:0] data_q;
	logic [2:0]                    cnt_q;
	logic                          take;

	assign out_valid = (cnt_q != 3'd0);
	assign out_byte  = data_q[mbp_pkg::WORD_BITS-1 -: mbp_pkg::BYTE_BITS];
	assign last      = (cnt_q == 3'd1);
	assign take      = out_valid && out_ready;
	// refill when idle, or as the final byte of the current job leaves
	assign pop       = !q_status.empty && (cnt_q == 3'd0 || (take && cnt_q == 3'd1));

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= head_job.data;
		end else if (take) begin
			data_q <= data_q << mbp_pkg::BYTE_BITS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (pop) begin
			cnt_q <= head_job.nbytes;
		end else if (take) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* rtl/msb_first_bit_packer_core.sv */
// MSB-first bit packer, top level: front, job queue and byte serialiser.
// Depends on mbp_pkg, mbp_front, mbp_queue and mbp_back.
//
// Packs bit fields into a byte stream, earliest bit in bit 7 of each byte.
// A write item (mode 0) appends the low bit_count bits of value (counts above
// 32 count as 32) after the pending bits; every byte it completes comes out as
// one beat, up to four per item, with last set on the item's final byte. A
// flush item (mode 1) pads the pending bits with zeros to a byte and sends that
// one byte with last set; with nothing pending it gives no beat. Items that
// complete no byte give no beat. The front merges each item into the pending
// bits in the cycle it is accepted and queues the completed bytes; the back
// sends one byte per cycle while out_ready is high and it holds bytes.
// Throughput is therefore set by the output port: an item yields zero to four
// bytes, and the front takes new items while the queue has room. An item's
// bytes are registered in the job queue, then in the back's output register.
// in_ready drops only while the job queue (QUEUE_DEPTH entries) is full.
module msb_first_bit_packer_core #(
	parameter int unsigned QUEUE_DEPTH = mbp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [31:0] value,
	input  logic [5:0]  bit_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last
);

	logic               q_push;
	logic               q_pop;
	mbp_pkg::job_t      push_job;
	mbp_pkg::job_t      head_job;
	mbp_pkg::q_status_t q_status;

	// Front: merge each accepted beat with the pending bits
	mbp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.value     (value),
		.bit_count (bit_count),
		.q_status  (q_status),
		.push      (q_push),
		.push_job  (push_job)
	);

	// Queue: hold completed-byte jobs so either side can stall alone
	mbp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head_job (head_job),
		.status   (q_status)
	);

	// Back: send each job's bytes, one beat per cycle while out_ready is high
	mbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_job  (head_job),
		.q_status  (q_status),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last)
	);

	// Bytes of one item leave back to back: no gap before its last beat
	a_item_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> out_valid)
		else $error("gap inside an item's byte run");

	// Never push into a full queue unless a pop frees a slot
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && !q_pop) |-> !q_status.full)
		else $error("job queue overflow");

	// Never pop an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_status.empty)
		else $error("job queue underflow");

endmodule

/* bench/testbench.sv */
// Self-checking testbench for msb_first_bit_packer_core: directed table, then random items.
// Depends on mbp_pkg and the block RTL; bytes are checked against a local model or typed rows.
module testbench;

	typedef struct {
		mbp_pkg::mode_t mode;
		logic [31:0]    value;
		logic [5:0]     count;
		bit             typed;      // expected bytes written in by hand
		int             n_typed;
		logic [31:0]    bytes_typed; // left-aligned, first byte in [31:24]
	} stim_row_t;

	typedef struct packed {
		logic [7:0] octet;
		logic       tail;
	} out_beat_t;

	localparam int RANDOM_ITEMS = 106;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        mode;
	logic [31:0] value;
	logic [5:0]  bit_count;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        last;

	// packer model state: bits not yet forming a byte, right aligned
	logic [6:0]  held_bits;
	logic [2:0]  held_count;

	out_beat_t   awaited_bytes[$];
	stim_row_t   directed_rows[$];
	int          mismatches;
	int          phase;
	int          send_idle_pct;
	int          recv_idle_pct;

	msb_first_bit_packer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.value     (value),
		.bit_count (bit_count),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("msb_first_bit_packer_core: mismatch");
		$finish;
	end

	// Merge one item into the held bits and return the bytes it completes, left-aligned.
	task automatic pack_item(input mbp_pkg::mode_t m, input logic [31:0] v,
			input logic [5:0] c, output int n, output logic [31:0] bytes);
		logic [63:0] acc;
		int          len;
		int          total;
		begin
			n = 0;
			bytes = '0;
			if (m == mbp_pkg::MODE_FLUSH) begin
				if (held_count == 0)
					return;
				len = mbp_pkg::BYTE_BITS - held_count;
				acc = 64'(held_bits) << len;
			end else begin
				len = (c > mbp_pkg::WORD_BITS) ? mbp_pkg::WORD_BITS : c;
				acc = (64'(held_bits) << len) | (64'(v) & ((64'd1 << len) - 64'd1));
			end
			total = held_count + len;
			n = total / mbp_pkg::BYTE_BITS;
			for (int k = 0; k < n; k++)
				bytes[31 - 8*k -: 8] = 8'(acc >> (total - 8*(k + 1)));
			held_count = 3'(total % mbp_pkg::BYTE_BITS);
			held_bits = 7'(acc & ((64'd1 << held_count) - 64'd1));
		end
	endtask

	task automatic add_row(input mbp_pkg::mode_t m, input logic [31:0] v, input logic [5:0] c,
			input bit typed, input int n, input logic [31:0] bytes);
		stim_row_t r;
		begin
			r.mode = m;
			r.value = v;
			r.count = c;
			r.typed = typed;
			r.n_typed = n;
			r.bytes_typed = bytes;
			directed_rows.push_back(r);
		end
	endtask

	// Offer one item, wait for its beat, then queue the bytes it should produce.
	task automatic send_item(input stim_row_t r);
		int          n;
		logic [31:0] bytes;
		begin
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
			in_valid  <= 1'b1;
			mode      <= r.mode;
			value     <= r.value;
			bit_count <= r.count;
			do @(posedge clk); while (!in_ready);
			pack_item(r.mode, r.value, r.count, n, bytes);
			if (r.typed) begin
				n = r.n_typed;
				bytes = r.bytes_typed;
			end
			for (int k = 0; k < n; k++)
				awaited_bytes.push_back('{octet: bytes[31 - 8*k -: 8], tail: (k == n - 1)});
		end
	endtask

	// Set the idle mix: sender light and receiver heavy, then swapped, then none.
	task automatic set_phase(input int p);
		begin
			phase = p;
			unique case (p)
				0: begin send_idle_pct = 6;  recv_idle_pct = 76; end
				1: begin send_idle_pct = 76; recv_idle_pct = 6;  end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
		end
	endtask

	// Receiver: random stalls, plus one long hold-off once the sender stops idling.
	initial begin
		int  hold_left;
		bit  held_off;
		hold_left = 0;
		held_off = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (!held_off && phase == 2) begin
				held_off = 1'b1;
				hold_left = 60;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Compare every output beat with the oldest awaited byte.
	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_bytes.size() == 0) begin
				$error("unexpected beat: out_byte=%02h last=%0b", out_byte, last);
				mismatches++;
			end else begin
				want = awaited_bytes.pop_front();
				if (out_byte !== want.octet) begin
					$error("out_byte: expected %02h, got %02h", want.octet, out_byte);
					mismatches++;
				end
				if (last !== want.tail) begin
					$error("last: expected %0b, got %0b", want.tail, last);
					mismatches++;
				end
			end
		end
	end

	initial begin
		stim_row_t r;
		int        pick;
		mismatches = 0;
		held_bits = '0;
		held_count = '0;
		set_phase(0);
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = 1'b0;
		value = '0;
		bit_count = '0;

		// extremes, saturation, empty flush, zero-bit write, partial bytes
		add_row(mbp_pkg::MODE_WRITE, 32'hDEADBEEF, 6'd32, 1, 4, 32'hDEADBEEF);
		add_row(mbp_pkg::MODE_FLUSH, 32'h0,        6'd0,  1, 0, 32'h0);
		add_row(mbp_pkg::MODE_WRITE, 32'hFFFFFFFF, 6'd0,  1, 0, 32'h0);
		add_row(mbp_pkg::MODE_WRITE, 32'hFFFFFFFF, 6'd63, 1, 4, 32'hFFFFFFFF);
		add_row(mbp_pkg::MODE_WRITE, 32'h00000005, 6'd3,  1, 0, 32'h0);
		add_row(mbp_pkg::MODE_FLUSH, 32'h0,        6'd0,  1, 1, 32'hA0000000);
		add_row(mbp_pkg::MODE_WRITE, 32'hFFFFFFFF, 6'd1,  1, 0, 32'h0);
		add_row(mbp_pkg::MODE_WRITE, 32'h00000000, 6'd32, 1, 4, 32'h80000000);
		add_row(mbp_pkg::MODE_FLUSH, 32'hFFFFFFFF, 6'd63, 1, 1, 32'h00000000);
		add_row(mbp_pkg::MODE_WRITE, 32'h0000007F, 6'd7,  1, 0, 32'h0);
		add_row(mbp_pkg::MODE_WRITE, 32'hFFFFFFFF, 6'd1,  1, 1, 32'hFF000000);
		add_row(mbp_pkg::MODE_WRITE, 32'h0000007F, 6'd7,  1, 0, 32'h0);
		add_row(mbp_pkg::MODE_WRITE, 32'hFFFFFFFF, 6'd32, 1, 4, 32'hFFFFFFFF);
		add_row(mbp_pkg::MODE_FLUSH, 32'h0,        6'd0,  1, 1, 32'hFE000000);
		add_row(mbp_pkg::MODE_WRITE, 32'h12345678, 6'd40, 0, 0, 32'h0);
		add_row(mbp_pkg::MODE_WRITE, 32'hAAAAAAAA, 6'd31, 0, 0, 32'h0);
		add_row(mbp_pkg::MODE_WRITE, 32'h55555555, 6'd17, 0, 0, 32'h0);
		add_row(mbp_pkg::MODE_FLUSH, 32'h0,        6'd0,  0, 0, 32'h0);
		add_row(mbp_pkg::MODE_WRITE, 32'h00000003, 6'd2,  0, 0, 32'h0);
		add_row(mbp_pkg::MODE_WRITE, 32'hFFFF0000, 6'd16, 0, 0, 32'h0);
		add_row(mbp_pkg::MODE_WRITE, 32'h00000001, 6'd8,  0, 0, 32'h0);
		add_row(mbp_pkg::MODE_WRITE, 32'h80000000, 6'd33, 0, 0, 32'h0);
		add_row(mbp_pkg::MODE_WRITE, 32'h0000000F, 6'd5,  0, 0, 32'h0);
		add_row(mbp_pkg::MODE_FLUSH, 32'hC0FFEE00, 6'd12, 0, 0, 32'h0);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i]);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3)
				set_phase(1);
			else if (i == 2 * RANDOM_ITEMS / 3)
				set_phase(2);
			r.mode = ($urandom_range(99) < 15) ? mbp_pkg::MODE_FLUSH : mbp_pkg::MODE_WRITE;
			r.value = $urandom;
			pick = $urandom_range(9);
			if (pick == 0)
				r.count = 6'($urandom_range(63, 33));
			else if (pick == 1)
				r.count = 6'd32;
			else
				r.count = 6'($urandom_range(32));
			r.typed = 1'b0;
			r.n_typed = 0;
			r.bytes_typed = '0;
			send_item(r);
		end
		@(negedge clk);
		in_valid <= 1'b0;

		// drain, then keep the clock running to catch any stray beat
		while (awaited_bytes.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0)
			$display("msb_first_bit_packer_core: match");
		else
			$display("msb_first_bit_packer_core: mismatch");
		$finish;
	end

endmodule
